### rtl/core/cmrp_pkg.sv
// Shared types and constants for the Catmull-Rom path evaluator.
// Used by cmrp_front, cmrp_queue, cmrp_back and the top level.
package cmrp_pkg;

  localparam int MAX_POINTS = 256;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = 9;
  localparam int COORD_W    = 32;
  localparam int FRAC_W     = 24;
  localparam int T_W        = FRAC_W + 1;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_EVAL  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // what the back end does with a queued beat
  typedef enum logic [1:0] {
    OP_STORE = 2'd0,
    OP_PASS  = 2'd1,
    OP_EVAL  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    B_IDLE = 3'd0,
    B_READ = 3'd1,
    B_INIT = 3'd2,
    B_MUL  = 3'd3,
    B_ACC  = 3'd4,
    B_FIN  = 3'd5
  } bst_e;

  typedef struct packed {
    op_e                          op;
    logic [COORD_W-1:0]           x;
    logic [COORD_W-1:0]           y;
    logic [COORD_W-1:0]           z;
    logic [3:0][ADDR_W-1:0]       idx;
    logic [T_W-1:0]               frac;
    logic [CNT_W-1:0]             count;
    logic                         status;
  } entry_t;

endpackage

### rtl/core/cmrp_front.sv
// Front end: accepts command beats, keeps the point count and loop flag,
// maps t onto a segment and its four neighbor indices. Depends on cmrp_pkg.
module cmrp_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    command_i,
  input  logic signed [31:0]            point_x_i,
  input  logic signed [31:0]            point_y_i,
  input  logic signed [31:0]            point_z_i,
  input  logic signed [31:0]            param_t_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic                          full_i,
  output logic                          push_o,
  output cmrp_pkg::entry_t              push_entry_o
);

  localparam logic [cmrp_pkg::T_W-1:0] OneT = cmrp_pkg::T_W'(1) << cmrp_pkg::FRAC_W;

  logic                          loop_q;
  logic [cmrp_pkg::CNT_W-1:0]    count_q, count_d;
  logic                          accept;
  logic [cmrp_pkg::T_W-1:0]      u;
  logic [cmrp_pkg::CNT_W-1:0]    segs;
  logic [33:0]                   q;
  logic [9:0]                    seg;
  logic [cmrp_pkg::T_W-1:0]      loc;
  logic signed [11:0]            sidx [4];
  logic signed [11:0]            widx [4];
  logic signed [11:0]            nn;
  cmrp_pkg::entry_t              ent;

  assign accept     = in_valid_i & ~full_i;
  assign in_stall_o = full_i;
  assign push_o     = accept;
  assign push_entry_o = ent;

  always_comb begin
    if (loop_q) begin
      u = {1'b0, param_t_i[cmrp_pkg::FRAC_W-1:0]};
    end else if (param_t_i[31]) begin
      u = '0;
    end else if (param_t_i > 32'sd16777216) begin
      u = OneT;
    end else begin
      u = param_t_i[cmrp_pkg::T_W-1:0];
    end
    segs = loop_q ? count_q : count_q - 1'b1;
    q    = 34'(u) * 34'(segs);
    seg  = q[33:24];
    loc  = {1'b0, q[cmrp_pkg::FRAC_W-1:0]};
    if (seg >= {1'b0, segs}) begin
      if (loop_q) begin
        seg = '0;
        loc = '0;
      end else begin
        seg = {1'b0, segs - 1'b1};
        loc = OneT;
      end
    end
    nn = $signed({3'b000, count_q});
    for (int k = 0; k < 4; k++) begin
      sidx[k] = $signed({2'b00, seg}) + 12'(k) - 12'sd1;
      if (loop_q) begin
        if (sidx[k] < 0) begin
          widx[k] = sidx[k] + nn;
        end else if (sidx[k] >= nn) begin
          widx[k] = sidx[k] - nn;
        end else begin
          widx[k] = sidx[k];
        end
      end else begin
        if (sidx[k] < 0) begin
          widx[k] = '0;
        end else if (sidx[k] >= nn) begin
          widx[k] = nn - 12'sd1;
        end else begin
          widx[k] = sidx[k];
        end
      end
    end
  end

  always_comb begin
    count_d    = count_q;
    ent.op     = cmrp_pkg::OP_PASS;
    ent.x      = point_x_i;
    ent.y      = point_y_i;
    ent.z      = point_z_i;
    ent.frac   = loc;
    ent.status = 1'b0;
    for (int k = 0; k < 4; k++) begin
      ent.idx[k] = widx[k][cmrp_pkg::ADDR_W-1:0];
    end
    case (cmrp_pkg::cmd_e'(command_i))
      cmrp_pkg::CMD_ADD: begin
        if (count_q == cmrp_pkg::CNT_W'(cmrp_pkg::MAX_POINTS)) begin
          ent.status = 1'b1;
        end else begin
          ent.op     = cmrp_pkg::OP_STORE;
          ent.idx[0] = count_q[cmrp_pkg::ADDR_W-1:0];
          count_d    = count_q + 1'b1;
        end
      end
      cmrp_pkg::CMD_CLEAR: begin
        count_d = '0;
      end
      cmrp_pkg::CMD_EVAL: begin
        if (count_q == '0) begin
          ent.op = cmrp_pkg::OP_PASS;
        end else if (count_q == cmrp_pkg::CNT_W'(1)) begin
          // single point: every neighbor is point zero
          ent.op   = cmrp_pkg::OP_EVAL;
          ent.idx  = '0;
          ent.frac = '0;
        end else begin
          ent.op = cmrp_pkg::OP_EVAL;
        end
      end
      default: begin
        ent.op = cmrp_pkg::OP_PASS;
      end
    endcase
    ent.count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      loop_q  <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (cfg_we_i) begin
        loop_q <= cfg_wdata_i;
      end
    end
  end

endmodule

### rtl/core/cmrp_queue.sv
// Two-entry queue between front and back end.
// Depends on cmrp_pkg for the entry type.
module cmrp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cmrp_pkg::entry_t  push_entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output cmrp_pkg::entry_t  pop_entry_o,
  output logic              empty_o
);

  cmrp_pkg::entry_t mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       fill_q;

  assign full_o      = fill_q == 2'd2;
  assign empty_o     = fill_q == 2'd0;
  assign pop_entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      fill_q <= fill_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

### rtl/core/cmrp_back.sv
// Back end: point memories, power terms and the shared multiply-accumulate
// for the cubic, plus the output register. Depends on cmrp_pkg.
module cmrp_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  cmrp_pkg::entry_t              entry_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            pos_x_o,
  output logic signed [31:0]            pos_y_o,
  output logic signed [31:0]            pos_z_o,
  output logic [cmrp_pkg::CNT_W-1:0]    stored_points_o,
  output logic                          status_o
);

  localparam int W = cmrp_pkg::COORD_W;

  cmrp_pkg::bst_e state_q, state_d;

  logic [W-1:0] x_mem [cmrp_pkg::MAX_POINTS];
  logic [W-1:0] y_mem [cmrp_pkg::MAX_POINTS];
  logic [W-1:0] z_mem [cmrp_pkg::MAX_POINTS];
  logic [W-1:0] rd_x_q, rd_y_q, rd_z_q;
  logic [cmrp_pkg::ADDR_W-1:0] rd_addr;
  logic         wr_en;

  cmrp_pkg::entry_t             cur_q;
  logic [2:0][3:0][W-1:0]       pnt_q;
  logic [2:0]                   rd_cnt_q;
  logic [cmrp_pkg::T_W-1:0]     t2_q, t3_q;
  logic [1:0]                   axis_q, term_q;
  logic                         half_q;
  logic signed [44:0]           prod_q;
  logic signed [63:0]           acc_q;
  logic [2:0][W-1:0]            res_q;
  logic                         out_vld_q;
  logic [cmrp_pkg::CNT_W-1:0]   out_cnt_q;
  logic                         out_st_q;

  logic [49:0]                  pow_prod;
  logic signed [35:0]           pa [4];
  logic signed [35:0]           coef;
  logic [cmrp_pkg::T_W-1:0]     tsel;
  logic signed [18:0]           mop_a;
  logic signed [25:0]           mop_t;
  logic signed [63:0]           addend;
  logic signed [63:0]           shv;
  logic [W-1:0]                 satv;
  logic                         last_term;

  assign out_valid_o     = out_vld_q;
  assign pos_x_o         = res_q[0];
  assign pos_y_o         = res_q[1];
  assign pos_z_o         = res_q[2];
  assign stored_points_o = out_cnt_q;
  assign status_o        = out_st_q;

  assign pop_o   = (state_q == cmrp_pkg::B_IDLE) && !empty_i && !out_vld_q;
  assign wr_en   = pop_o && (entry_i.op == cmrp_pkg::OP_STORE);
  assign rd_addr = cur_q.idx[rd_cnt_q[1:0]];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      x_mem[entry_i.idx[0]] <= entry_i.x;
      y_mem[entry_i.idx[0]] <= entry_i.y;
      z_mem[entry_i.idx[0]] <= entry_i.z;
    end
    rd_x_q <= x_mem[rd_addr];
    rd_y_q <= y_mem[rd_addr];
    rd_z_q <= z_mem[rd_addr];
  end

  // coefficient, power term, operand halves, power products and saturated result for the current step
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pa[k] = 36'($signed(pnt_q[axis_q][k]));
    end
    case (term_q)
      2'd0:    coef = pa[2] - pa[0];
      2'd1:    coef = (pa[0] <<< 1) - ((pa[1] <<< 2) + pa[1]) + (pa[2] <<< 2) - pa[3];
      default: coef = ((pa[1] <<< 1) + pa[1]) - ((pa[2] <<< 1) + pa[2]) + pa[3] - pa[0];
    endcase
    case (term_q)
      2'd0:    tsel = cur_q.frac;
      2'd1:    tsel = t2_q;
      default: tsel = t3_q;
    endcase
    mop_a  = half_q ? {coef[35], coef[35:18]} : $signed({1'b0, coef[17:0]});
    mop_t  = $signed({1'b0, tsel});
    addend = half_q ? ({{19{prod_q[44]}}, prod_q} <<< 18) : {{19{prod_q[44]}}, prod_q};
    pow_prod = (rd_cnt_q == 3'd0) ? 50'(cur_q.frac) * 50'(cur_q.frac)
                                  : 50'(t2_q) * 50'(cur_q.frac);
    shv = (acc_q + 64'sd16777216) >>> 25;
    if (shv > 64'sd2147483647) begin
      satv = {1'b0, {(W-1){1'b1}}};
    end else if (shv < -64'sd2147483648) begin
      satv = {1'b1, {(W-1){1'b0}}};
    end else begin
      satv = shv[W-1:0];
    end
    last_term = (term_q == 2'd2) && half_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      cmrp_pkg::B_IDLE: begin
        if (pop_o && entry_i.op == cmrp_pkg::OP_EVAL) begin
          state_d = cmrp_pkg::B_READ;
        end
      end
      cmrp_pkg::B_READ: begin
        if (rd_cnt_q == 3'd4) begin
          state_d = cmrp_pkg::B_INIT;
        end
      end
      cmrp_pkg::B_INIT: state_d = cmrp_pkg::B_MUL;
      cmrp_pkg::B_MUL:  state_d = cmrp_pkg::B_ACC;
      cmrp_pkg::B_ACC:  state_d = last_term ? cmrp_pkg::B_FIN : cmrp_pkg::B_MUL;
      cmrp_pkg::B_FIN:  state_d = (axis_q == 2'd2) ? cmrp_pkg::B_IDLE : cmrp_pkg::B_INIT;
      default:          state_d = cmrp_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cmrp_pkg::B_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (pop_o && entry_i.op != cmrp_pkg::OP_EVAL) begin
        out_vld_q <= 1'b1;
      end
      if (state_q == cmrp_pkg::B_FIN && axis_q == 2'd2) begin
        out_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      cmrp_pkg::B_IDLE: begin
        if (pop_o) begin
          cur_q     <= entry_i;
          rd_cnt_q  <= '0;
          axis_q    <= '0;
          out_cnt_q <= entry_i.count;
          out_st_q  <= entry_i.status;
          res_q     <= '0;
        end
      end
      cmrp_pkg::B_READ: begin
        // memory data is registered, so it arrives in the cycle after its address
        if (rd_cnt_q != 3'd0) begin
          pnt_q[0][rd_cnt_q[1:0] - 2'd1] <= rd_x_q;
          pnt_q[1][rd_cnt_q[1:0] - 2'd1] <= rd_y_q;
          pnt_q[2][rd_cnt_q[1:0] - 2'd1] <= rd_z_q;
        end
        if (rd_cnt_q == 3'd0) begin
          t2_q <= pow_prod[48:24];
        end
        if (rd_cnt_q == 3'd1) begin
          t3_q <= pow_prod[48:24];
        end
        rd_cnt_q <= rd_cnt_q + 1'b1;
      end
      cmrp_pkg::B_INIT: begin
        acc_q  <= 64'($signed(pnt_q[axis_q][1])) <<< 25;
        term_q <= '0;
        half_q <= 1'b0;
      end
      cmrp_pkg::B_MUL: begin
        prod_q <= mop_a * mop_t;
      end
      cmrp_pkg::B_ACC: begin
        acc_q  <= acc_q + addend;
        half_q <= ~half_q;
        if (half_q) begin
          term_q <= term_q + 1'b1;
        end
      end
      cmrp_pkg::B_FIN: begin
        res_q[axis_q] <= satv;
        axis_q        <= axis_q + 1'b1;
      end
      default: begin
        rd_cnt_q <= '0;
      end
    endcase
  end

endmodule

### rtl/core/catmull_rom_path_evaluator.sv
// Top level of the Catmull-Rom path evaluator: front end, beat queue, back end.
// Depends on cmrp_pkg, cmrp_front, cmrp_queue and cmrp_back.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-------------------------------------------
//   input    | in_valid_i / in_stall_o | command_i, point_x/y/z_i, param_t_i
//   output   | out_valid_o/out_stall_i | pos_x/y/z_o, stored_points_o, status_o
//   config   | cfg_we_i                | cfg_wdata_i (loop enable)
//
// Add, clear and unused commands go through the beat queue and load the output register when popped.
// Evaluate leaves the queue, reads the four points from memory (t^2, t^3 computed alongside),
// then per axis runs an init step, 6 multiply/accumulate pairs on one shared 19x26 multiplier
// and a round/saturate step.
// The back end pops the next beat only once the output register is empty again.
// The front end keeps taking beats until the queue fills.
// Reset clears count, loop flag and handshake state; point memories are not cleared.
module catmull_rom_path_evaluator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  command_i,
  input  logic signed [31:0]          point_x_i,
  input  logic signed [31:0]          point_y_i,
  input  logic signed [31:0]          point_z_i,
  input  logic signed [31:0]          param_t_i,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [31:0]          pos_x_o,
  output logic signed [31:0]          pos_y_o,
  output logic signed [31:0]          pos_z_o,
  output logic [8:0]                  stored_points_o,
  output logic                        status_o
);

  logic             push, pop, full, empty;
  cmrp_pkg::entry_t push_entry, pop_entry;

  cmrp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .param_t_i    (param_t_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .full_i       (full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  cmrp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .pop_entry_o  (pop_entry),
    .empty_o      (empty)
  );

  cmrp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .entry_i         (pop_entry),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pos_x_o         (pos_x_o),
    .pos_y_o         (pos_y_o),
    .pos_z_o         (pos_z_o),
    .stored_points_o (stored_points_o),
    .status_o        (status_o)
  );

endmodule

### tb/catmull_rom_path_evaluator_test.sv
// Self-checking bench for catmull_rom_path_evaluator: random and directed add, clear
// and evaluate beats, checked against a fixed-point spline predictor. Depends on cmrp_pkg.
module catmull_rom_path_evaluator_test;

  typedef struct {
    logic signed [31:0] px, py, pz;
    logic [8:0]         npts;
    logic               full;
  } pos_beat_t;

  class path_scoreboard;
    longint xs[256], ys[256], zs[256];
    int unsigned npts;
    bit loop_on;
    pos_beat_t pending[$];
    int errors;

    function longint fl_shift(longint v, int k);
      longint low;
      low = v & ((longint'(1) << k) - 1);
      return (v - low) / (longint'(1) << k);
    endfunction

    function longint spline_axis(longint p0, longint p1, longint p2, longint p3,
                                 longint u, longint t2, longint t3);
      longint a[3], tk[3], hs, ls, h;
      hs = 0; ls = 0;
      a[0] = p2 - p0;
      a[1] = 2*p0 - 5*p1 + 4*p2 - p3;
      a[2] = -p0 + 3*p1 - 3*p2 + p3;
      tk[0] = u; tk[1] = t2; tk[2] = t3;
      for (int i = 0; i < 3; i++) begin
        hs += fl_shift(a[i], 24) * tk[i];
        ls += (a[i] & 64'hFFFFFF) * tk[i];
      end
      h = fl_shift(2*p1 + hs + (ls >>> 24) + 1, 1);
      if (h > 64'sh7FFFFFFF) h = 64'sh7FFFFFFF;
      if (h < -64'sh80000000) h = -64'sh80000000;
      return h;
    endfunction

    function int pick(longint i);
      longint n;
      n = longint'(npts);
      if (loop_on) return int'(((i % n) + n) % n);
      if (i < 0) return 0;
      if (i >= n) return int'(n - 1);
      return int'(i);
    endfunction

    function void note_beat(cmrp_pkg::cmd_e cmd, logic signed [31:0] x, y, z, t);
      pos_beat_t e;
      longint u, segs, q, seg, loc, t2, t3;
      int i0, i1, i2, i3;
      e.px = 0; e.py = 0; e.pz = 0; e.full = 0;
      case (cmd)
        cmrp_pkg::CMD_ADD: begin
          if (npts >= 256) e.full = 1;
          else begin
            xs[npts] = x; ys[npts] = y; zs[npts] = z; npts++;
          end
        end
        cmrp_pkg::CMD_CLEAR: npts = 0;
        cmrp_pkg::CMD_EVAL: begin
          if (npts == 1) begin
            e.px = 32'(xs[0]); e.py = 32'(ys[0]); e.pz = 32'(zs[0]);
          end else if (npts > 1) begin
            if (loop_on) u = longint'(t) & 64'hFFFFFF;
            else if (t < 0) u = 0;
            else if (longint'(t) > 64'h1000000) u = 64'h1000000;
            else u = t;
            segs = loop_on ? npts : npts - 1;
            q = u * segs; seg = q >>> 24; loc = q & 64'hFFFFFF;
            if (seg >= segs) begin
              if (loop_on) begin seg = 0; loc = 0; end
              else begin seg = segs - 1; loc = 64'h1000000; end
            end
            i0 = pick(seg-1); i1 = pick(seg); i2 = pick(seg+1); i3 = pick(seg+2);
            t2 = (loc * loc) >>> 24; t3 = (t2 * loc) >>> 24;
            e.px = 32'(spline_axis(xs[i0], xs[i1], xs[i2], xs[i3], loc, t2, t3));
            e.py = 32'(spline_axis(ys[i0], ys[i1], ys[i2], ys[i3], loc, t2, t3));
            e.pz = 32'(spline_axis(zs[i0], zs[i1], zs[i2], zs[i3], loc, t2, t3));
          end
        end
        default: ;
      endcase
      e.npts = npts[8:0];
      pending.push_back(e);
    endfunction

    function void check_beat(logic signed [31:0] x, y, z, logic [8:0] n, logic s);
      pos_beat_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected"); errors++; return;
      end
      e = pending.pop_front();
      if (x !== e.px) begin $error("pos_x exp %0d got %0d", e.px, x); errors++; end
      if (y !== e.py) begin $error("pos_y exp %0d got %0d", e.py, y); errors++; end
      if (z !== e.pz) begin $error("pos_z exp %0d got %0d", e.pz, z); errors++; end
      if (n !== e.npts) begin
        $error("stored_points exp %0d got %0d", e.npts, n); errors++;
      end
      if (s !== e.full) begin $error("status exp %0d got %0d", e.full, s); errors++; end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, in_stall_o;
  logic [1:0] command_i = cmrp_pkg::CMD_NONE;
  logic signed [31:0] point_x_i = 0, point_y_i = 0, point_z_i = 0, param_t_i = 0;
  logic cfg_we_i = 0, cfg_wdata_i = 0;
  logic out_valid_o, out_stall_i = 0;
  logic signed [31:0] pos_x_o, pos_y_o, pos_z_o;
  logic [8:0] stored_points_o;
  logic status_o;

  path_scoreboard sb = new();
  int idle_pct = 24;
  int hold_off = 0;
  int beats_in = 0, beats_out = 0, evals = 0;

  catmull_rom_path_evaluator dut (.*);

  initial forever #5 clk_i = ~clk_i;

  // receiver: random stall, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_beat(pos_x_o, pos_y_o, pos_z_o, stored_points_o, status_o);
      beats_out++;
    end
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall_i <= 1;
    end else out_stall_i <= ($urandom_range(99) < idle_pct);
  end

  function logic signed [31:0] rnd_coord();
    case ($urandom_range(5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $urandom_range(2000000) - 1000000;
      default: return $urandom;
    endcase
  endfunction

  function logic signed [31:0] rnd_t();
    case ($urandom_range(5))
      0: return $urandom_range(32'h1000000);
      1: return 32'sh1000000;
      2: return 0;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(cmrp_pkg::cmd_e cmd, logic signed [31:0] x, y, z, t);
    // drop valid only while idling
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1; command_i <= cmd;
    point_x_i <= x; point_y_i <= y; point_z_i <= z; param_t_i <= t;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_beat(cmd, x, y, z, t);
    beats_in++;
    if (cmd == cmrp_pkg::CMD_EVAL) evals++;
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_loop(bit v);
    drain();
    cfg_we_i <= 1; cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.loop_on = v;
  endtask

  task automatic random_path(int beats);
    int n;
    n = $urandom_range(1) ? $urandom_range(6) : $urandom_range(40);
    send(cmrp_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
    for (int i = 0; i < n; i++)
      send(cmrp_pkg::CMD_ADD, rnd_coord(), rnd_coord(), rnd_coord(), $urandom);
    for (int i = 0; i < beats; i++) begin
      case ($urandom_range(19))
        0: send(cmrp_pkg::CMD_NONE, $urandom, $urandom, $urandom, $urandom);
        1, 2: send(cmrp_pkg::CMD_ADD, rnd_coord(), rnd_coord(), rnd_coord(), $urandom);
        default: send(cmrp_pkg::CMD_EVAL, $urandom, $urandom, $urandom, rnd_t());
      endcase
    end
  endtask

  initial begin
    #100000000;
    $display("catmull_rom_path_evaluator_test: errors");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    set_loop(0);
    // empty path, single point, then extremes
    send(cmrp_pkg::CMD_EVAL, 0, 0, 0, 32'sh800000);
    send(cmrp_pkg::CMD_ADD, 32'sh7FFFFFFF, 32'sh80000000, 32'sh12345, 0);
    send(cmrp_pkg::CMD_EVAL, 0, 0, 0, 32'sh7FFFFFFF);
    send(cmrp_pkg::CMD_ADD, 32'sh80000000, 32'sh7FFFFFFF, -5, 0);
    send(cmrp_pkg::CMD_ADD, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 0);
    send(cmrp_pkg::CMD_EVAL, 0, 0, 0, 32'sh80000000);
    send(cmrp_pkg::CMD_EVAL, 0, 0, 0, 32'sh7FFFFFFF);
    send(cmrp_pkg::CMD_EVAL, 0, 0, 0, 32'sh1000000);
    send(cmrp_pkg::CMD_EVAL, 0, 0, 0, 32'sh555555);
    send(cmrp_pkg::CMD_NONE, -1, -1, -1, -1);
    set_loop(1);
    send(cmrp_pkg::CMD_EVAL, 0, 0, 0, -32'sh400000);
    send(cmrp_pkg::CMD_EVAL, 0, 0, 0, 32'sh1000000);
    send(cmrp_pkg::CMD_EVAL, 0, 0, 0, 32'shFFFFFF);
    // fill the store, overflow it, check wrap across the whole store
    send(cmrp_pkg::CMD_CLEAR, 0, 0, 0, 0);
    for (int i = 0; i < 258; i++)
      send(cmrp_pkg::CMD_ADD, rnd_coord(), rnd_coord(), rnd_coord(), 0);
    send(cmrp_pkg::CMD_EVAL, 0, 0, 0, 32'shFFFFFF);
    set_loop(0);
    send(cmrp_pkg::CMD_EVAL, 0, 0, 0, 32'shFFFFFF);
    // receiver holds off while the sender keeps offering
    fork
      hold_off = 300;
      random_path(40);
    join
    // sender pauses until everything has drained
    drain();
    for (int ph = 0; ph < 10; ph++) begin
      idle_pct = (ph == 4) ? 0 : 24;
      set_loop(ph[0]);
      random_path(20);
    end
    drain();
    $display("covered %0d input beats, %0d evaluates, %0d results",
             beats_in, evals, beats_out);
    if (sb.errors == 0) $display("catmull_rom_path_evaluator_test: clean");
    else $display("catmull_rom_path_evaluator_test: errors");
    $finish;
  end
endmodule
